[design/lssm_pkg.sv]
// ----------------------------------------------------------------------------
// lssm_pkg
// Types, codes and sizes shared by the LRU slot set manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lssm_pkg;

    localparam int DEFAULT_NUM_SLOTS = 4;
    localparam int KEY_W             = 32;
    localparam int STAMP_W           = 32;
    localparam int MASK_W            = 4;
    localparam int SLOT_OUT_W        = 2;

    typedef enum logic [1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_SERVICE = 2'd1,
        REQ_LOOKUP  = 2'd2,
        REQ_RESET   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_PENDING  = 2'd1,
        ST_READY    = 2'd2,
        ST_EVICTING = 2'd3
    } slot_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch a new request word, clear scan trackers
        logic step;    // examine the slot under the scan pointer
        logic commit;  // update slot state and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage : lssm_pkg

`default_nettype wire

[design/lssm_if.sv]
// ----------------------------------------------------------------------------
// lssm_if
// Request and response channels of the LRU slot set manager.
// ----------------------------------------------------------------------------
`default_nettype none

interface lssm_req_if
    import lssm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [KEY_W-1:0]      key_id;
    logic [MASK_W-1:0]     in_use_mask;
    logic                  load_failed;

    modport source (output valid, req_type, key_id, in_use_mask, load_failed,
                    input ready);
    modport sink   (input valid, req_type, key_id, in_use_mask, load_failed,
                    output ready);
endinterface : lssm_req_if

interface lssm_rsp_if
    import lssm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  evicted;

    modport source (output valid, hit, slot_index, evicted, input ready);
    modport sink   (input valid, hit, slot_index, evicted, output ready);
endinterface : lssm_rsp_if

`default_nettype wire

[design/lssm_ctrl.sv]
// ----------------------------------------------------------------------------
// lssm_ctrl
// Sequencer: accept a request, scan slots one per cycle, commit the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_ctrl
    import lssm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule : lssm_ctrl

`default_nettype wire

[design/lssm_dp.sv]
// ----------------------------------------------------------------------------
// lssm_dp
// Slot state, scan trackers, commit logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_dp
    import lssm_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            req_type,
    input  wire logic [KEY_W-1:0]      key_id,
    input  wire logic [MASK_W-1:0]     in_use_mask,
    input  wire logic                  load_failed,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       hit,
    output logic [SLOT_OUT_W-1:0]      slot_index,
    output logic                       evicted
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PIN_W  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // request word
    req_t                 req_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic                 failed_reg;

    // slot state
    slot_state_t          status_reg [NUM_SLOTS];
    slot_state_t          status_next[NUM_SLOTS];
    logic [KEY_W-1:0]     rkey_reg   [NUM_SLOTS];
    logic [KEY_W-1:0]     rkey_next  [NUM_SLOTS];
    logic [KEY_W-1:0]     wkey_reg   [NUM_SLOTS];
    logic [KEY_W-1:0]     wkey_next  [NUM_SLOTS];
    logic [STAMP_W-1:0]   stamp_reg  [NUM_SLOTS];
    logic [STAMP_W-1:0]   stamp_next [NUM_SLOTS];
    logic [STAMP_W-1:0]   use_clock_reg, use_clock_next;

    // scan trackers
    logic [SLOT_W-1:0]    idx_reg;
    logic                 found_reg;
    logic [SLOT_W-1:0]    found_idx_reg;
    slot_state_t          found_st_reg;
    logic [KEY_W-1:0]     found_wkey_reg;
    logic                 empty_found_reg;
    logic [SLOT_W-1:0]    empty_idx_reg;
    logic                 lru_found_reg;
    logic [SLOT_W-1:0]    lru_idx_reg;
    logic [STAMP_W-1:0]   lru_stamp_reg;

    // result register
    logic                  out_valid_reg;
    logic                  hit_reg, hit_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                  evicted_reg, evicted_next;

    // scan step
    slot_state_t          cur_st;
    logic [KEY_W-1:0]     cur_rkey, cur_wkey, cur_have;
    logic [STAMP_W-1:0]   cur_stamp;
    logic [PIN_W-1:0]     pin_ext;
    logic                 key_zero, hit_here, stop_here, take_empty, take_lru;

    // commit
    logic                 acq_new, acq_evict;
    logic [SLOT_W-1:0]    pick;
    logic [SLOT_W-1:0]    res_idx;

    assign cur_st    = status_reg[idx_reg];
    assign cur_rkey  = rkey_reg[idx_reg];
    assign cur_wkey  = wkey_reg[idx_reg];
    assign cur_stamp = stamp_reg[idx_reg];
    assign cur_have  = (cur_st == ST_READY) ? cur_rkey : cur_wkey;
    assign key_zero  = (key_reg == '0);
    // slots past the mask width are never pinned
    assign pin_ext   = PIN_W'(mask_reg);

    always_comb
    begin
        hit_here   = 1'b0;
        stop_here  = 1'b0;
        take_empty = 1'b0;
        take_lru   = 1'b0;
        case (req_reg)
            REQ_ACQUIRE:
            begin
                hit_here   = !key_zero && (cur_st != ST_EMPTY) && (cur_have == key_reg);
                stop_here  = key_zero || hit_here;
                take_empty = !key_zero && (cur_st == ST_EMPTY) && !empty_found_reg;
                take_lru   = !key_zero && (cur_st == ST_READY) && !pin_ext[idx_reg] &&
                             (!lru_found_reg || (cur_stamp < lru_stamp_reg));
            end
            REQ_SERVICE:
            begin
                hit_here  = (cur_st == ST_EVICTING) || (cur_st == ST_PENDING);
                stop_here = hit_here;
            end
            REQ_LOOKUP:
            begin
                hit_here  = !key_zero && (cur_st == ST_READY) && (cur_rkey == key_reg);
                stop_here = key_zero || hit_here;
            end
            REQ_RESET:
            begin
                stop_here = 1'b1;
            end
            default:
            begin
                stop_here = 1'b1;
            end
        endcase
    end

    assign sts.scan_done = stop_here || (idx_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign acq_new   = !found_reg && (empty_found_reg || lru_found_reg);
    assign acq_evict = !empty_found_reg;
    assign pick      = empty_found_reg ? empty_idx_reg : lru_idx_reg;

    always_comb
    begin
        status_next    = status_reg;
        rkey_next      = rkey_reg;
        wkey_next      = wkey_reg;
        stamp_next     = stamp_reg;
        use_clock_next = use_clock_reg;
        hit_next       = 1'b0;
        res_idx        = '0;
        evicted_next   = 1'b0;
        case (req_reg)
            REQ_ACQUIRE:
            begin
                if (found_reg)
                begin
                    // key already held or wanted: touch only
                    use_clock_next            = use_clock_reg + 1'b1;
                    stamp_next[found_idx_reg] = use_clock_next;
                end
                else if (acq_new)
                begin
                    use_clock_next    = use_clock_reg + 1'b1;
                    stamp_next[pick]  = use_clock_next;
                    wkey_next[pick]   = key_reg;
                    status_next[pick] = acq_evict ? ST_EVICTING : ST_PENDING;
                    hit_next          = 1'b1;
                    res_idx           = pick;
                    evicted_next      = acq_evict;
                end
            end
            REQ_SERVICE:
            begin
                if (found_reg)
                begin
                    if (found_st_reg == ST_EVICTING)
                    begin
                        rkey_next[found_idx_reg]   = '0;
                        status_next[found_idx_reg] = ST_PENDING;
                    end
                    else
                    begin
                        if (failed_reg)
                        begin
                            status_next[found_idx_reg] = ST_EMPTY;
                        end
                        else
                        begin
                            rkey_next[found_idx_reg]   = found_wkey_reg;
                            status_next[found_idx_reg] = ST_READY;
                        end
                        wkey_next[found_idx_reg] = '0;
                    end
                    hit_next = 1'b1;
                    res_idx  = found_idx_reg;
                end
            end
            REQ_LOOKUP:
            begin
                hit_next = found_reg;
                res_idx  = found_reg ? found_idx_reg : '0;
            end
            REQ_RESET:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    status_next[i] = ST_EMPTY;
                    rkey_next[i]   = '0;
                    wkey_next[i]   = '0;
                end
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
        slot_next = SLOT_OUT_W'(res_idx);
    end

    // request word, tracker payloads and result word: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg    <= req_t'(req_type);
            key_reg    <= key_id;
            mask_reg   <= in_use_mask;
            failed_reg <= load_failed;
        end
        if (cmd.step && hit_here)
        begin
            found_idx_reg  <= idx_reg;
            found_st_reg   <= cur_st;
            found_wkey_reg <= cur_wkey;
        end
        if (cmd.step && take_empty)
        begin
            empty_idx_reg <= idx_reg;
        end
        if (cmd.step && take_lru)
        begin
            lru_idx_reg   <= idx_reg;
            lru_stamp_reg <= cur_stamp;
        end
        if (cmd.commit)
        begin
            hit_reg     <= hit_next;
            slot_reg    <= slot_next;
            evicted_reg <= evicted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            lru_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            use_clock_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_EMPTY;
                rkey_reg[i]   <= '0;
                wkey_reg[i]   <= '0;
                stamp_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.start)
            begin
                idx_reg         <= '0;
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
                lru_found_reg   <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (hit_here)
                begin
                    found_reg <= 1'b1;
                end
                if (take_empty)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (take_lru)
                begin
                    lru_found_reg <= 1'b1;
                end
                if (!sts.scan_done)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                status_reg    <= status_next;
                rkey_reg      <= rkey_next;
                wkey_reg      <= wkey_next;
                stamp_reg     <= stamp_next;
                use_clock_reg <= use_clock_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign slot_index = slot_reg;
    assign evicted    = evicted_reg;

endmodule : lssm_dp

`default_nettype wire

[design/lru_slot_set_manager_core.sv]
// ----------------------------------------------------------------------------
// lru_slot_set_manager_core
// LRU slot allocator: acquire, service step, lookup and reset of a slot set.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | word
//  --------+-----+----------------+------------------------------------------
//  req     | in  | valid / ready  | req_type, key_id, in_use_mask, load_failed
//  rsp     | out | valid / ready  | hit, slot_index, evicted
//
//  An item passes an accept step, a scan of the slots (one slot per cycle,
//  stopping at the first matching slot) and a commit step.
//  One request is in flight at a time; the next is accepted once the previous
//  one is committed to the result register, which may still be waiting.
//  A stalled rsp holds the commit cycle until the result register frees.
//  rst_n empties all slots and zeroes keys, stamps and the use clock; a reset request clears slots and keys only.
//
`default_nettype none

module lru_slot_set_manager_core
    import lssm_pkg::*;
#(
    parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lssm_req_if.sink    req,
    lssm_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;

    lssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lssm_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req.req_type),
        .key_id      (req.key_id),
        .in_use_mask (req.in_use_mask),
        .load_failed (req.load_failed),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .hit         (rsp.hit),
        .slot_index  (rsp.slot_index),
        .evicted     (rsp.evicted)
    );

endmodule : lru_slot_set_manager_core

`default_nettype wire

[design/lssm_checker.sv]
// ----------------------------------------------------------------------------
// lssm_checker
// Port-level checks for the LRU slot set manager.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_checker
    import lssm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  req_valid,
    input wire logic                  req_ready,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire logic                  rsp_hit,
    input wire logic [SLOT_OUT_W-1:0] rsp_slot_index,
    input wire logic                  rsp_evicted
);

    // an eviction is always a claim
    a_evict_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted |-> rsp_hit)
        else $error("evicted without hit");

    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_slot_index == '0)
        else $error("slot_index nonzero on miss");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
        $stable(rsp_slot_index) && $stable(rsp_evicted))
        else $error("stalled response word changed");

endmodule : lssm_checker

bind lru_slot_set_manager_core lssm_checker u_lssm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_slot_index (rsp.slot_index),
    .rsp_evicted    (rsp.evicted)
);

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_slot_set_manager_core.
// Runs a table of directed requests, then about 1150 random ones on a small
// key pool so slots fill, get evicted and get refreshed. Both channels stall
// at random. Every reply is compared field by field, in order, with the
// reply predicted by an in-bench model of the slot set.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import lssm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = 4;
    localparam int NUM_RANDOM = 1150;
    localparam int CALM_FIRST = 400;
    localparam int CALM_LAST  = 560;
    localparam int DRAIN_AT   = 700;
    localparam int IDLE_PCT   = 38;
    localparam int TAIL_WAIT  = 20;
    localparam int CYCLE_CAP  = 200000;
    localparam int POOL_SIZE  = 6;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
    } slot_reply_t;

    typedef struct packed {
        req_t              rt;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic              fail;
        logic              fixed;
        slot_reply_t       reply;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    lssm_req_if req();
    lssm_rsp_if rsp();

    lru_slot_set_manager_core #(.NUM_SLOTS(NUM_SLOTS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // slot set as the bench sees it
    slot_state_t       slot_st  [NUM_SLOTS];
    logic [KEY_W-1:0]  held_key [NUM_SLOTS];
    logic [KEY_W-1:0]  want_key [NUM_SLOTS];
    logic [STAMP_W-1:0] stamp   [NUM_SLOTS];
    logic [STAMP_W-1:0] use_clk;

    slot_reply_t awaited_replies [$];
    int          err_cnt = 0;
    int          cyc = 0;
    bit          calm = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    dir_row_t dir_rows [25] = '{
        // fresh reset: nothing busy, nothing resident
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{REQ_LOOKUP,  32'h0000_0001, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        // zero key is rejected
        '{REQ_ACQUIRE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{REQ_LOOKUP,  32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        // fill all slots, second ask for the same key only bumps its stamp
        '{REQ_ACQUIRE, 32'hFFFF_FFFF, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{REQ_ACQUIRE, 32'hFFFF_FFFF, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{REQ_ACQUIRE, 32'h0000_0001, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd1, 1'b0}},
        '{REQ_ACQUIRE, 32'h0000_0002, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd2, 1'b0}},
        '{REQ_ACQUIRE, 32'h0000_0003, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd3, 1'b0}},
        // no empty slot and nothing ready to evict
        '{REQ_ACQUIRE, 32'h0000_0004, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        // failed load frees slot 0, the rest become ready
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b1, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd1, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd2, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd3, 1'b0}},
        '{REQ_LOOKUP,  32'h0000_0003, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd3, 1'b0}},
        '{REQ_ACQUIRE, 32'h8000_0000, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b0, 1'b1, '{1'b1, 2'd0, 1'b0}},
        '{REQ_ACQUIRE, 32'h0000_0002, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        // every slot pinned: nothing to evict
        '{REQ_ACQUIRE, 32'h0000_0005, 4'hF, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}},
        // LRU victim among unpinned ready slots, then walk it back
        '{REQ_ACQUIRE, 32'h0000_0005, 4'h1, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0}},
        '{REQ_LOOKUP,  32'h0000_0001, 4'h0, 1'b0, 1'b0, '{1'b0, 2'd0, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'h0, 1'b1, 1'b0, '{1'b0, 2'd0, 1'b0}},
        '{REQ_SERVICE, 32'h0000_0000, 4'hE, 1'b1, 1'b0, '{1'b0, 2'd0, 1'b0}},
        // reset all, then nothing is resident
        '{REQ_RESET,   32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1, '{1'b0, 2'd0, 1'b0}},
        '{REQ_LOOKUP,  32'h0000_0003, 4'h0, 1'b0, 1'b1, '{1'b0, 2'd0, 1'b0}}
    };

    function automatic void clear_slots(bit with_stamps);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_st[i]  = ST_EMPTY;
            held_key[i] = '0;
            want_key[i] = '0;
            if (with_stamps)
                stamp[i] = '0;
        end
        if (with_stamps)
            use_clk = '0;
    endfunction

    function automatic slot_reply_t predict_reply(req_t rt, logic [KEY_W-1:0] key,
                                                  logic [MASK_W-1:0] mask, logic fail);
        slot_reply_t      r;
        int               pick;
        bit               evict;
        bit               pinned;
        logic [KEY_W-1:0] have;
        r = '0;
        pick = -1;
        evict = 1'b0;
        case (rt)
            REQ_ACQUIRE:
            begin
                if (key != '0)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        have = (slot_st[i] == ST_READY) ? held_key[i] : want_key[i];
                        if (pick < 0 && slot_st[i] != ST_EMPTY && have == key)
                            pick = i;
                    end
                    if (pick >= 0)
                    begin
                        // already held or wanted: touch only
                        use_clk = use_clk + 1'b1;
                        stamp[pick] = use_clk;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (pick < 0 && slot_st[i] == ST_EMPTY)
                                pick = i;
                        if (pick < 0)
                        begin
                            evict = 1'b1;
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                pinned = (i < MASK_W) ? mask[i] : 1'b0;
                                if (slot_st[i] == ST_READY && !pinned &&
                                    (pick < 0 || stamp[i] < stamp[pick]))
                                    pick = i;
                            end
                        end
                        if (pick >= 0)
                        begin
                            want_key[pick] = key;
                            use_clk = use_clk + 1'b1;
                            stamp[pick] = use_clk;
                            slot_st[pick] = evict ? ST_EVICTING : ST_PENDING;
                            r.hit = 1'b1;
                            r.slot = pick[SLOT_OUT_W-1:0];
                            r.evicted = evict;
                        end
                    end
                end
            end
            REQ_SERVICE:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (pick < 0 && slot_st[i] == ST_EVICTING)
                    begin
                        held_key[i] = '0;
                        slot_st[i] = ST_PENDING;
                        pick = i;
                    end
                    else if (pick < 0 && slot_st[i] == ST_PENDING)
                    begin
                        if (fail)
                            slot_st[i] = ST_EMPTY;
                        else
                        begin
                            held_key[i] = want_key[i];
                            slot_st[i] = ST_READY;
                        end
                        want_key[i] = '0;
                        pick = i;
                    end
                end
                if (pick >= 0)
                begin
                    r.hit = 1'b1;
                    r.slot = pick[SLOT_OUT_W-1:0];
                end
            end
            REQ_LOOKUP:
            begin
                if (key != '0)
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (pick < 0 && slot_st[i] == ST_READY && held_key[i] == key)
                            pick = i;
                if (pick >= 0)
                begin
                    r.hit = 1'b1;
                    r.slot = pick[SLOT_OUT_W-1:0];
                end
            end
            default:
                clear_slots(1'b0);
        endcase
        return r;
    endfunction

    // drive one request word, wait for it to be taken, log its reply
    task automatic issue_request(input req_t rt, input logic [KEY_W-1:0] key,
                                 input logic [MASK_W-1:0] mask, input logic fail,
                                 input bit drain, input bit use_fixed,
                                 input slot_reply_t fixed_reply);
        slot_reply_t guess;
        if (drain)
            while (awaited_replies.size() != 0)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= rt;
        req.key_id      <= key;
        req.in_use_mask <= mask;
        req.load_failed <= fail;
        do
            @(posedge clk);
        while (!req.ready);
        guess = predict_reply(rt, key, mask, fail);
        awaited_replies.push_back(use_fixed ? fixed_reply : guess);
    endtask

    task automatic report_miss(input string what, input slot_reply_t want,
                               input slot_reply_t got);
        if (err_cnt < 10)
            $display("%0t: %s: expected hit=%0b slot=%0d evicted=%0b, got hit=%0b slot=%0d evicted=%0b",
                     $realtime, what, want.hit, want.slot, want.evicted,
                     got.hit, got.slot, got.evicted);
        err_cnt++;
    endtask

    // reply side: random stalls, in-order compare
    always @(posedge clk)
    begin
        slot_reply_t got;
        slot_reply_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.hit     = rsp.hit;
            got.slot    = rsp.slot_index;
            got.evicted = rsp.evicted;
            if (awaited_replies.size() == 0)
                report_miss("reply with nothing awaited", '0, got);
            else
            begin
                want = awaited_replies.pop_front();
                if (got.hit !== want.hit)
                    report_miss("hit mismatch", want, got);
                if (got.slot !== want.slot)
                    report_miss("slot_index mismatch", want, got);
                if (got.evicted !== want.evicted)
                    report_miss("evicted mismatch", want, got);
            end
        end
        rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int   sel;
        int   slot_pick;
        req_t rt;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic              fail;

        req.valid       = 1'b0;
        req.req_type    = REQ_ACQUIRE;
        req.key_id      = '0;
        req.in_use_mask = '0;
        req.load_failed = 1'b0;
        rsp.ready       = 1'b0;
        clear_slots(1'b1);
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].rt, dir_rows[i].key, dir_rows[i].mask,
                          dir_rows[i].fail, 1'b0, dir_rows[i].fixed, dir_rows[i].reply);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            if ($urandom_range(0, 39) == 0)
                key_pool[$urandom_range(3, POOL_SIZE - 1)] = $urandom;

            sel = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 19) == 0)
                key = $urandom;
            else if ($urandom_range(0, 39) == 0)
                key = '0;
            mask = ($urandom_range(0, 1) == 0) ? 4'h0 : MASK_W'($urandom_range(0, 15));
            fail = ($urandom_range(0, 4) == 0);
            if (sel < 42)
                rt = REQ_ACQUIRE;
            else if (sel < 77)
                rt = REQ_SERVICE;
            else if (sel < 97)
                rt = REQ_LOOKUP;
            else
                rt = REQ_RESET;
            // lookups mostly aim at something resident
            if (rt == REQ_LOOKUP && sel < 90)
            begin
                slot_pick = $urandom_range(0, NUM_SLOTS - 1);
                if (slot_st[slot_pick] == ST_READY)
                    key = held_key[slot_pick];
            end
            issue_request(rt, key, mask, fail, n == DRAIN_AT, 1'b0, '0);
        end
        calm = 1'b0;
        req.valid <= 1'b0;

        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : testbench

`default_nettype wire
